FILE: sv/oaht_pkg.sv
package oaht_pkg;

    localparam int DATA_W     = 32;
    localparam int MOD_W      = 17;
    localparam int MOD_STEPS  = 4;
    localparam int SHIFT_W    = 4;
    localparam int SHIFT_MIN  = 3;
    localparam int SLOT_OUT_W = 10;
    localparam int CNT_OUT_W  = 11;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd10;

    localparam logic [DATA_W-1:0] HASH_FREE = 32'd0;
    localparam logic [DATA_W-1:0] HASH_TOMB = 32'd1;
    localparam logic [DATA_W-1:0] HASH_MIN  = 32'd2;

    typedef enum logic [1:0] {
        FN_LOOKUP = 2'd0,
        FN_INSERT = 2'd1,
        FN_REMOVE = 2'd2,
        FN_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STS_DONE      = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK,
        S_FIN
    } state_t;

    typedef struct packed {
        func_t              func;
        logic [DATA_W-1:0]  digest;
        logic [DATA_W-1:0]  key;
        logic [DATA_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        logic                  found;
        logic [DATA_W-1:0]     read_value;
        status_t               status;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic [CNT_OUT_W-1:0]  live_entries;
        logic [CNT_OUT_W-1:0]  occupied_entries;
    } out_item_t;

    typedef struct packed {
        logic hash;
        logic key;
        logic value;
    } wen_t;

    function automatic logic [MOD_W-1:0] probe_prime(input logic [4:0] s);
        logic [MOD_W-1:0] p;
        begin
            case (s)
                5'd0:    p = 17'd1;
                5'd1:    p = 17'd2;
                5'd2:    p = 17'd3;
                5'd3:    p = 17'd7;
                5'd4:    p = 17'd13;
                5'd5:    p = 17'd31;
                5'd6:    p = 17'd61;
                5'd7:    p = 17'd127;
                5'd8:    p = 17'd251;
                5'd9:    p = 17'd509;
                5'd10:   p = 17'd1021;
                5'd11:   p = 17'd2039;
                5'd12:   p = 17'd4093;
                5'd13:   p = 17'd8191;
                5'd14:   p = 17'd16381;
                5'd15:   p = 17'd32749;
                5'd16:   p = 17'd65521;
                default: p = 17'd1;
            endcase
            return p;
        end
    endfunction

endpackage

FILE: sv/open_address_hash_table.sv
// Lookup, insert and remove first reduce the hash to a start slot in the iterative modulo unit
// (4 bits per cycle), then probe slots one at a time, each through a read state and a check
// state on the one slot memory read port, before the result is loaded.
// One operation at a time; the next transfer in follows the result.
// Clear writes all CAPACITY slots (1024 by default): one slot cleared per cycle.
// Reset: the same clearing pass runs first; no transfer in until it is done.
module open_address_hash_table #(
    parameter int LOG_CAPACITY = 10,
    parameter int KEY_WIDTH    = 32,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [oaht_pkg::SHIFT_W-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  oaht_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output oaht_pkg::out_item_t            out_data
);

    localparam int LW = LOG_CAPACITY;

    oaht_pkg::state_t               state_reg, state_next;
    logic [oaht_pkg::SHIFT_W-1:0]   shift_reg;
    logic [4:0]                     shift_eff;
    logic [LW:0]                    size_w;
    logic [LW-1:0]                  mask;

    oaht_pkg::func_t                func_reg, func_next;
    logic [oaht_pkg::DATA_W-1:0]    hash_reg, hash_next;
    logic [KEY_WIDTH-1:0]           key_reg, key_next;
    logic [VALUE_WIDTH-1:0]         value_reg, value_next;
    logic [oaht_pkg::DATA_W-1:0]    in_hash;

    logic [LW-1:0]                  idx_reg, idx_next;
    logic [LW-1:0]                  n_reg, n_next;
    logic [LW-1:0]                  tomb_reg, tomb_next;
    logic                           have_tomb_reg, have_tomb_next;
    logic                           hit_reg, hit_next;
    logic                           free_reg, free_next;
    logic [LW-1:0]                  end_reg, end_next;
    logic [LW-1:0]                  clr_cnt_reg, clr_cnt_next;
    logic                           clr_op_reg, clr_op_next;
    logic [LW:0]                    live_reg, live_next;
    logic [LW:0]                    occ_reg, occ_next;

    logic                           out_valid_reg, out_valid_next;
    oaht_pkg::out_item_t            out_data_reg, out_data_next;

    logic                           accept;
    logic                           load_ok;
    logic                           load;
    logic                           clr_last;
    logic                           mod_start;
    logic                           mod_done;
    logic [oaht_pkg::MOD_W-1:0]     mod_rem;

    oaht_pkg::wen_t                 wen;
    logic [LW-1:0]                  wr_addr;
    logic [oaht_pkg::DATA_W-1:0]    wr_hash;
    logic [oaht_pkg::DATA_W-1:0]    rd_hash;
    logic [KEY_WIDTH-1:0]           rd_key;
    logic [VALUE_WIDTH-1:0]         rd_value;

    logic                           is_free, is_hit, tomb_new, have_tomb_now, stop;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != oaht_pkg::S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign load_ok   = !out_valid_reg || !out_stall;
    assign clr_last  = &clr_cnt_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        if (shift_reg < oaht_pkg::SHIFT_MIN)
        begin
            shift_eff = 5'(oaht_pkg::SHIFT_MIN);
        end
        else if (32'(shift_reg) > LOG_CAPACITY)
        begin
            shift_eff = 5'(LOG_CAPACITY);
        end
        else
        begin
            shift_eff = {1'b0, shift_reg};
        end
    end

    assign size_w  = (LW + 1)'(1) << shift_eff;
    assign mask    = LW'(size_w - 1'b1);
    assign in_hash = (in_data.digest < oaht_pkg::HASH_MIN) ? oaht_pkg::HASH_MIN
                                                           : in_data.digest;

    assign mod_start = accept && (in_data.func != oaht_pkg::FN_CLEAR);

    oaht_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (in_hash),
        .divisor   (oaht_pkg::probe_prime(shift_eff)),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    oaht_store #(
        .LOG_CAPACITY (LOG_CAPACITY),
        .KEY_WIDTH    (KEY_WIDTH),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_store (
        .clk      (clk),
        .wen      (wen),
        .wr_addr  (wr_addr),
        .wr_hash  (wr_hash),
        .wr_key   (key_reg),
        .wr_value (value_reg),
        .rd_addr  (idx_reg),
        .rd_hash  (rd_hash),
        .rd_key   (rd_key),
        .rd_value (rd_value)
    );

    // probe decode
    assign is_free       = (rd_hash == oaht_pkg::HASH_FREE);
    assign is_hit        = (rd_hash == hash_reg) && (rd_key == key_reg);
    assign tomb_new      = (rd_hash == oaht_pkg::HASH_TOMB) && !have_tomb_reg;
    assign have_tomb_now = have_tomb_reg || tomb_new;
    assign stop          = is_free || is_hit || (n_reg == mask);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            oaht_pkg::S_CLEAR:
            begin
                if (clr_last && (!clr_op_reg || load_ok))
                begin
                    state_next = oaht_pkg::S_IDLE;
                end
            end
            oaht_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (in_data.func == oaht_pkg::FN_CLEAR) ? oaht_pkg::S_CLEAR
                                                                       : oaht_pkg::S_MOD;
                end
            end
            oaht_pkg::S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = oaht_pkg::S_READ;
                end
            end
            oaht_pkg::S_READ:
            begin
                state_next = oaht_pkg::S_CHECK;
            end
            oaht_pkg::S_CHECK:
            begin
                state_next = stop ? oaht_pkg::S_FIN : oaht_pkg::S_READ;
            end
            oaht_pkg::S_FIN:
            begin
                if (load_ok)
                begin
                    state_next = oaht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = oaht_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        func_next      = func_reg;
        hash_next      = hash_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        tomb_next      = tomb_reg;
        have_tomb_next = have_tomb_reg;
        hit_next       = hit_reg;
        free_next      = free_reg;
        end_next       = end_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_op_next    = clr_op_reg;
        live_next      = live_reg;
        occ_next       = occ_reg;
        wen            = '0;
        wr_addr        = end_reg;
        wr_hash        = hash_reg;
        load           = 1'b0;
        out_data_next  = out_data_reg;

        case (state_reg)
            oaht_pkg::S_CLEAR:
            begin
                wen.hash = 1'b1;
                wr_addr  = clr_cnt_reg;
                wr_hash  = oaht_pkg::HASH_FREE;
                if (!clr_last)
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
                else if (!clr_op_reg || load_ok)
                begin
                    clr_cnt_next = '0;
                    clr_op_next  = 1'b0;
                    if (clr_op_reg)
                    begin
                        load                           = 1'b1;
                        out_data_next.found            = 1'b0;
                        out_data_next.read_value       = '0;
                        out_data_next.status           = oaht_pkg::STS_DONE;
                        out_data_next.slot_index       = '0;
                        out_data_next.live_entries     = '0;
                        out_data_next.occupied_entries = '0;
                    end
                end
            end
            oaht_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    func_next  = in_data.func;
                    hash_next  = in_hash;
                    key_next   = KEY_WIDTH'(in_data.key);
                    value_next = VALUE_WIDTH'(in_data.value);
                    if (in_data.func == oaht_pkg::FN_CLEAR)
                    begin
                        clr_op_next  = 1'b1;
                        clr_cnt_next = '0;
                        live_next    = '0;
                        occ_next     = '0;
                    end
                end
            end
            oaht_pkg::S_MOD:
            begin
                if (mod_done)
                begin
                    idx_next       = LW'(mod_rem) & mask;
                    n_next         = '0;
                    have_tomb_next = 1'b0;
                end
            end
            oaht_pkg::S_CHECK:
            begin
                have_tomb_next = have_tomb_now;
                if (tomb_new)
                begin
                    tomb_next = idx_reg;
                end
                if (stop)
                begin
                    hit_next  = is_hit;
                    free_next = is_free;
                    end_next  = (is_hit || !have_tomb_now) ? idx_reg
                              : (tomb_new ? idx_reg : tomb_reg);
                end
                else
                begin
                    idx_next = (idx_reg + n_reg + 1'b1) & mask;
                    n_next   = n_reg + 1'b1;
                end
            end
            oaht_pkg::S_FIN:
            begin
                if (load_ok)
                begin
                    load                     = 1'b1;
                    out_data_next.found      = hit_reg;
                    out_data_next.read_value = '0;
                    out_data_next.status     = oaht_pkg::STS_DONE;
                    case (func_reg)
                        oaht_pkg::FN_LOOKUP:
                        begin
                            if (hit_reg)
                            begin
                                out_data_next.read_value = oaht_pkg::DATA_W'(rd_value);
                            end
                            else
                            begin
                                out_data_next.status = oaht_pkg::STS_NOT_FOUND;
                            end
                        end
                        oaht_pkg::FN_INSERT:
                        begin
                            if (hit_reg)
                            begin
                                wen.value = 1'b1;
                            end
                            else if (have_tomb_reg || free_reg)
                            begin
                                wen       = '1;
                                live_next = live_reg + 1'b1;
                                if (!have_tomb_reg)
                                begin
                                    occ_next = occ_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                out_data_next.status = oaht_pkg::STS_FULL;
                            end
                        end
                        oaht_pkg::FN_REMOVE:
                        begin
                            if (hit_reg)
                            begin
                                wen.hash = 1'b1;
                                wr_hash  = oaht_pkg::HASH_TOMB;
                                if (live_reg != '0)
                                begin
                                    live_next = live_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                out_data_next.status = oaht_pkg::STS_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    out_data_next.slot_index       = oaht_pkg::SLOT_OUT_W'(end_reg);
                    out_data_next.live_entries     = oaht_pkg::CNT_OUT_W'(live_next);
                    out_data_next.occupied_entries = oaht_pkg::CNT_OUT_W'(occ_next);
                end
            end
            default:
            begin
            end
        endcase

        out_valid_next = load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oaht_pkg::S_CLEAR;
            shift_reg     <= oaht_pkg::SHIFT_RESET;
            clr_cnt_reg   <= '0;
            clr_op_reg    <= 1'b0;
            live_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            have_tomb_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_op_reg    <= clr_op_next;
            live_reg      <= live_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            have_tomb_reg <= have_tomb_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            if (cfg_valid && cfg_ready)
            begin
                shift_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        hash_reg     <= hash_next;
        key_reg      <= key_next;
        value_reg    <= value_next;
        idx_reg      <= idx_next;
        tomb_reg     <= tomb_next;
        end_reg      <= end_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTH
    a_live_le_occ: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= occ_reg)
        else $error("live count above occupied count");

    a_mod_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == oaht_pkg::S_MOD))
        else $error("modulo result outside modulo wait");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            ($past(state_reg) == oaht_pkg::S_FIN || $past(state_reg) == oaht_pkg::S_CLEAR))
        else $error("result raised outside finish or clear");
`endif

endmodule

FILE: sv/oaht_mod.sv
module oaht_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [oaht_pkg::DATA_W-1:0]   dividend,
    input  logic [oaht_pkg::MOD_W-1:0]    divisor,
    output logic                          done,
    output logic [oaht_pkg::MOD_W-1:0]    remainder
);

    localparam int ITERS = oaht_pkg::DATA_W / oaht_pkg::MOD_STEPS;
    localparam int CW    = $clog2(ITERS);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CW-1:0]                 cnt_reg;
    logic [oaht_pkg::DATA_W-1:0]   q_reg;
    logic [oaht_pkg::MOD_W-1:0]    d_reg;
    logic [oaht_pkg::MOD_W-1:0]    r_reg;
    logic [oaht_pkg::DATA_W-1:0]   q_next;
    logic [oaht_pkg::MOD_W-1:0]    r_next;

    // restoring remainder, several bits per cycle
    always_comb
    begin
        logic [oaht_pkg::MOD_W:0]    r_wide;
        logic [oaht_pkg::MOD_W-1:0]  r_tmp;
        logic [oaht_pkg::DATA_W-1:0] q_tmp;
        r_tmp = r_reg;
        q_tmp = q_reg;
        for (int i = 0; i < oaht_pkg::MOD_STEPS; i++)
        begin
            r_wide = {r_tmp, q_tmp[oaht_pkg::DATA_W-1]};
            if (r_wide >= {1'b0, d_reg})
            begin
                r_wide = r_wide - {1'b0, d_reg};
            end
            r_tmp = r_wide[oaht_pkg::MOD_W-1:0];
            q_tmp = q_tmp << 1;
        end
        r_next = r_tmp;
        q_next = q_tmp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(ITERS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            d_reg <= divisor;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign done      = done_reg;
    assign remainder = r_reg;

endmodule

FILE: sv/oaht_store.sv
module oaht_store #(
    parameter int LOG_CAPACITY = 10,
    parameter int KEY_WIDTH    = 32,
    parameter int VALUE_WIDTH  = 32
) (
    input  logic                          clk,
    input  oaht_pkg::wen_t                wen,
    input  logic [LOG_CAPACITY-1:0]       wr_addr,
    input  logic [oaht_pkg::DATA_W-1:0]   wr_hash,
    input  logic [KEY_WIDTH-1:0]          wr_key,
    input  logic [VALUE_WIDTH-1:0]        wr_value,
    input  logic [LOG_CAPACITY-1:0]       rd_addr,
    output logic [oaht_pkg::DATA_W-1:0]   rd_hash,
    output logic [KEY_WIDTH-1:0]          rd_key,
    output logic [VALUE_WIDTH-1:0]        rd_value
);

    localparam int DEPTH = 1 << LOG_CAPACITY;

    logic [oaht_pkg::DATA_W-1:0] hash_mem [DEPTH];
    logic [KEY_WIDTH-1:0]        key_mem  [DEPTH];
    logic [VALUE_WIDTH-1:0]      val_mem  [DEPTH];

    logic [oaht_pkg::DATA_W-1:0] rd_hash_reg;
    logic [KEY_WIDTH-1:0]        rd_key_reg;
    logic [VALUE_WIDTH-1:0]      rd_value_reg;

    always_ff @(posedge clk)
    begin
        if (wen.hash)
        begin
            hash_mem[wr_addr] <= wr_hash;
        end
        rd_hash_reg <= hash_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wen.key)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        rd_key_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wen.value)
        begin
            val_mem[wr_addr] <= wr_value;
        end
        rd_value_reg <= val_mem[rd_addr];
    end

    assign rd_hash  = rd_hash_reg;
    assign rd_key   = rd_key_reg;
    assign rd_value = rd_value_reg;

endmodule
